[rtl/soc_pkg.sv]
// Shared constants, register codes and types for the seat occupancy detector.
package soc_pkg;

    // Channel count and field widths
    localparam int MAX_CH      = 6;
    localparam int SAMPLE_W    = 12;
    localparam int SUM_W       = 15;
    localparam int HOLD_W      = 16;
    localparam int ROW_W       = 3;
    localparam int COUNT_W     = 3;

    // Reciprocal divide: exact floor quotient for any 15-bit sum and divisor 1..8
    localparam int RECIP_SHIFT = 18;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = SUM_W + RECIP_W;

    // Defaults for the top-level parameters
    localparam int CHANNELS_DEF = 6;
    localparam int ROWS_DEF     = 5;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS = 2'd1;

    // Register reset values
    localparam logic [SAMPLE_W-1:0] THRESHOLD_RST  = 12'd1000;
    localparam logic [HOLD_W-1:0]   HOLD_TICKS_RST = 16'd1000;

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [HOLD_W-1:0]   t_hold;

    // Stage load strobes shared by all lanes
    typedef struct packed {
        logic acc;    // row beat accepted
        logic last;   // row is the last of its block
        logic ld_div; // block sum moves into the divide stage
        logic ld_cmp; // average moves into the compare / hold stage
    } t_lane_ctl;

endpackage

[rtl/soc_lane.sv]
// One channel lane: accumulate a block, divide by the row count, threshold and hold timer.
module soc_lane
    import soc_pkg::*;
#(
    parameter int ROWS_PER_BLOCK = ROWS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_lane_ctl i_ctl,
    input  t_sample   i_sample,
    input  t_sample   i_threshold,
    input  t_hold     i_hold_ticks,
    output t_sample   o_average,
    output logic      o_occupied
);

    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((2 ** RECIP_SHIFT) + ROWS_PER_BLOCK - 1) / ROWS_PER_BLOCK);

    logic [SUM_W-1:0]  r_sum;
    logic [SUM_W-1:0]  r_blk_sum;
    t_sample           r_avg;
    t_sample           r_avg_cmp;
    t_hold             r_hold;
    logic              r_occ;

    logic [SUM_W-1:0]  w_sum_add;
    logic [PROD_W-1:0] w_prod;
    t_hold             n_hold;

    assign w_sum_add = r_sum + SUM_W'(i_sample);
    assign w_prod    = PROD_W'(r_blk_sum) * PROD_W'(RECIP);

    // Running sum: restart at each block end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_ctl.acc) begin
            r_sum <= i_ctl.last ? '0 : w_sum_add;
        end
    end

    // Capture the finished block sum
    always_ff @(posedge i_clk) begin
        if (i_ctl.acc && i_ctl.last) begin
            r_blk_sum <= w_sum_add;
        end
    end

    // Floor average by reciprocal multiply
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_div) begin
            r_avg <= w_prod[RECIP_SHIFT +: SAMPLE_W];
        end
    end

    // Reload below threshold, otherwise count a nonzero timer down
    always_comb begin
        if (r_avg < i_threshold) begin
            n_hold = i_hold_ticks;
        end else if (r_hold != '0) begin
            n_hold = r_hold - t_hold'(1);
        end else begin
            n_hold = r_hold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= '0;
        end else if (i_ctl.ld_cmp) begin
            r_hold <= n_hold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_cmp) begin
            r_avg_cmp <= r_avg;
            r_occ     <= (n_hold != '0);
        end
    end

    assign o_average  = r_avg_cmp;
    assign o_occupied = r_occ;

endmodule

[rtl/soc_merge.sv]
// Merge stage: gather lane results, count occupied seats, hold the result beat.
module soc_merge
    import soc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  t_sample           i_average [MAX_CH],
    input  logic [MAX_CH-1:0] i_occupied,
    input  logic              i_out_stall,
    output logic              o_advance,
    output logic              o_out_valid,
    output t_sample           o_average [MAX_CH],
    output logic [MAX_CH-1:0] o_occupied_mask,
    output logic [COUNT_W-1:0] o_occupied_count
);

    logic               r_vld;
    t_sample            r_avg [MAX_CH];
    logic [MAX_CH-1:0]  r_mask;
    logic [COUNT_W-1:0] r_count;

    // Output register free or draining this cycle
    assign o_advance = !r_vld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_advance) begin
            r_vld <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_advance) begin
            r_avg   <= i_average;
            r_mask  <= i_occupied;
            r_count <= COUNT_W'($countones(i_occupied));
        end
    end

    assign o_out_valid      = r_vld;
    assign o_average        = r_avg;
    assign o_occupied_mask  = r_mask;
    assign o_occupied_count = r_count;

endmodule

[rtl/seat_occupancy_detector.sv]
// Top level of the seat occupancy detector: row control, configuration and lanes.
//
// Each input beat is one scan row with a 12-bit sample per seat channel; one row is
// taken every clock cycle unless the input stalls. After ROWS_PER_BLOCK rows a result
// beat follows the last row through block-sum capture, reciprocal divide, threshold
// and hold timer, and merge, giving the floor average of every channel, a mask of seats
// whose hold timer is nonzero and their count. One lane per channel does the work in
// parallel; channels at or above CHANNELS report an average of zero and are never
// occupied. The input stalls only when the result pipeline is full and the output side
// stalls. Register 0 is the threshold, register 1 the hold time in blocks; writes are
// always ready, other indexes are ignored; new values apply at the next compare load.
module seat_occupancy_detector
    import soc_pkg::*;
#(
    parameter int CHANNELS       = CHANNELS_DEF,
    parameter int ROWS_PER_BLOCK = ROWS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [SAMPLE_W-1:0]   i_sample_0,
    input  logic [SAMPLE_W-1:0]   i_sample_1,
    input  logic [SAMPLE_W-1:0]   i_sample_2,
    input  logic [SAMPLE_W-1:0]   i_sample_3,
    input  logic [SAMPLE_W-1:0]   i_sample_4,
    input  logic [SAMPLE_W-1:0]   i_sample_5,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [SAMPLE_W-1:0]   o_average_0,
    output logic [SAMPLE_W-1:0]   o_average_1,
    output logic [SAMPLE_W-1:0]   o_average_2,
    output logic [SAMPLE_W-1:0]   o_average_3,
    output logic [SAMPLE_W-1:0]   o_average_4,
    output logic [SAMPLE_W-1:0]   o_average_5,
    output logic [MAX_CH-1:0]     o_occupied_mask,
    output logic [COUNT_W-1:0]    o_occupied_count,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS_PER_BLOCK - 1);

    t_sample           r_threshold;
    t_hold             r_hold_ticks;
    logic [ROW_W-1:0]  r_row;
    logic              r_v_blk;
    logic              r_v_div;
    logic              r_v_cmp;

    t_lane_ctl         w_ctl;
    t_sample           w_samp [MAX_CH];
    t_sample           w_avg_lane [MAX_CH];
    logic [MAX_CH-1:0] w_occ;
    t_sample           w_avg_out [MAX_CH];
    logic              w_adv_out;
    logic              w_en_cmp;
    logic              w_en_div;
    logic              w_ld_out;

    // Configuration writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold  <= THRESHOLD_RST;
            r_hold_ticks <= HOLD_TICKS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_THRESHOLD:  r_threshold  <= i_cfg_data[SAMPLE_W-1:0];
                CFG_HOLD_TICKS: r_hold_ticks <= i_cfg_data[HOLD_W-1:0];
                default:        ;
            endcase
        end
    end

    // Stage enables, back from the output register
    assign w_en_cmp = !r_v_cmp || w_adv_out;
    assign w_en_div = !r_v_div || w_en_cmp;
    assign w_ld_out = r_v_cmp && w_adv_out;

    // Stall only when the block-sum stage is full and cannot move on
    assign o_in_stall = r_v_blk && !w_en_div;

    assign w_ctl.acc    = i_in_valid && !o_in_stall;
    assign w_ctl.last   = (r_row == LAST_ROW);
    assign w_ctl.ld_div = r_v_blk && w_en_div;
    assign w_ctl.ld_cmp = r_v_div && w_en_cmp;

    // Row counter within the block
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
        end else if (w_ctl.acc) begin
            r_row <= w_ctl.last ? '0 : r_row + ROW_W'(1);
        end
    end

    // Pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_blk <= 1'b0;
            r_v_div <= 1'b0;
            r_v_cmp <= 1'b0;
        end else begin
            r_v_blk <= (w_ctl.acc && w_ctl.last) || (r_v_blk && !w_ctl.ld_div);
            r_v_div <= w_ctl.ld_div || (r_v_div && !w_ctl.ld_cmp);
            r_v_cmp <= w_ctl.ld_cmp || (r_v_cmp && !w_ld_out);
        end
    end

    assign w_samp[0] = i_sample_0;
    assign w_samp[1] = i_sample_1;
    assign w_samp[2] = i_sample_2;
    assign w_samp[3] = i_sample_3;
    assign w_samp[4] = i_sample_4;
    assign w_samp[5] = i_sample_5;

    // One lane per active channel; the rest report zero
    for (genvar c = 0; c < MAX_CH; c++) begin : g_lane
        if (c < CHANNELS) begin : g_on
            soc_lane #(
                .ROWS_PER_BLOCK (ROWS_PER_BLOCK)
            ) u_lane (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_sample     (w_samp[c]),
                .i_threshold  (r_threshold),
                .i_hold_ticks (r_hold_ticks),
                .o_average    (w_avg_lane[c]),
                .o_occupied   (w_occ[c])
            );
        end else begin : g_off
            assign w_avg_lane[c] = '0;
            assign w_occ[c]      = 1'b0;
        end
    end

    soc_merge u_merge (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_load           (r_v_cmp),
        .i_average        (w_avg_lane),
        .i_occupied       (w_occ),
        .i_out_stall      (i_out_stall),
        .o_advance        (w_adv_out),
        .o_out_valid      (o_out_valid),
        .o_average        (w_avg_out),
        .o_occupied_mask  (o_occupied_mask),
        .o_occupied_count (o_occupied_count)
    );

    assign o_average_0 = w_avg_out[0];
    assign o_average_1 = w_avg_out[1];
    assign o_average_2 = w_avg_out[2];
    assign o_average_3 = w_avg_out[3];
    assign o_average_4 = w_avg_out[4];
    assign o_average_5 = w_avg_out[5];

endmodule
